### src/alp_pkg.sv
// Package for the Accept-Language parser: byte codes, status codes, result word type
// and the q-value place weights. No dependencies.
`default_nettype none

package alp_pkg;

   localparam int NAME_MAX_DEFAULT = 32;

   // Widths of the result word's fields.
   localparam int CHAR_W   = 8;
   localparam int POS_W    = 5;
   localparam int LEN_W    = 6;
   localparam int QUAL_W   = 10;
   localparam int STATUS_W = 2;
   localparam int DIGIT_W  = 2;

   localparam logic [QUAL_W-1:0] QUALITY_FULL = 10'd1000;
   localparam logic [DIGIT_W-1:0] DIGITS_MAX  = 2'd3;

   // Header bytes the parser recognizes.
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_VIS_LO = 8'h21;
   localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_ONE   = 8'h31;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_SEMI  = 8'h3B;
   localparam logic [CHAR_W-1:0] CHAR_EQUAL = 8'h3D;
   localparam logic [CHAR_W-1:0] CHAR_Q     = 8'h71;
   localparam logic [CHAR_W-1:0] CHAR_VIS_HI = 8'h7E;

   // Status codes of a result word.
   localparam logic [STATUS_W-1:0] STATUS_PARSING = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ERROR   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_DISCARD = 2'd3;

   typedef struct packed {
      logic [CHAR_W-1:0]   char_echo;
      logic                is_name_char;
      logic [POS_W-1:0]    name_position;
      logic                entry_done;
      logic [QUAL_W-1:0]   quality;
      logic [LEN_W-1:0]    name_length;
      logic                is_wildcard;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // Weight in thousandths of the decimal digit at a given place after the point.
   function automatic logic [6:0] place_weight(input logic [DIGIT_W-1:0] place);
      logic [6:0] w;
      case (place)
         2'd0:    w = 7'd100;
         2'd1:    w = 7'd10;
         2'd2:    w = 7'd1;
         default: w = 7'd0;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### src/accept_language_parser.sv
// Top level of the Accept-Language header parser: byte-wide state machine with a
// two-deep result buffer. Depends on alp_pkg.
//
//   channel   direction  payload                                 handshake
//   req_      in         req_char_in                             req_valid / req_ready
//   rsp_      out        echo, name flags, entry summary, status rsp_valid / rsp_ready
//
// One byte is accepted per clock cycle while req_ready is high. Its result word is
// registered in the output register, or in the skid slot while that register waits; the
// state machine step and the q-value digit multiply-add are the only logic ahead of them.
// Reset (synchronous, active high) returns the parser to the start of a header and
// empties both result slots.
// The output register is backed by a skid slot, so one more byte is taken while a result
// waits; req_ready falls only once both slots hold results.
`default_nettype none

module accept_language_parser #(
   parameter int NAME_MAX = alp_pkg::NAME_MAX_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [alp_pkg::CHAR_W-1:0]   req_char_in,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [alp_pkg::CHAR_W-1:0]   rsp_char_echo,
   output logic                         rsp_is_name_char,
   output logic [alp_pkg::POS_W-1:0]    rsp_name_position,
   output logic                         rsp_entry_done,
   output logic [alp_pkg::QUAL_W-1:0]   rsp_quality,
   output logic [alp_pkg::LEN_W-1:0]    rsp_name_length,
   output logic                         rsp_is_wildcard,
   output logic [alp_pkg::STATUS_W-1:0] rsp_status
);

   // The name counter must hold NAME_MAX itself.
   localparam int CNT_W = $clog2(NAME_MAX + 1);

   // Parser states.
   localparam logic [3:0] ST_START      = 4'd0;
   localparam logic [3:0] ST_SEP        = 4'd1;
   localparam logic [3:0] ST_LANG       = 4'd2;
   localparam logic [3:0] ST_OWS1       = 4'd3;
   localparam logic [3:0] ST_SEMI       = 4'd4;
   localparam logic [3:0] ST_OWS2       = 4'd5;
   localparam logic [3:0] ST_Q          = 4'd6;
   localparam logic [3:0] ST_QEQ        = 4'd7;
   localparam logic [3:0] ST_ONE_INT    = 4'd8;
   localparam logic [3:0] ST_ONE_POINT  = 4'd9;
   localparam logic [3:0] ST_ONE_DEC    = 4'd10;
   localparam logic [3:0] ST_ZERO_INT   = 4'd11;
   localparam logic [3:0] ST_ZERO_POINT = 4'd12;
   localparam logic [3:0] ST_ZERO_DEC   = 4'd13;

   // Parser state.
   logic [3:0]                    state_ff, state_in;
   logic [alp_pkg::QUAL_W-1:0]    quality_ff, quality_in;
   logic [alp_pkg::DIGIT_W-1:0]   digits_ff, digits_in;
   logic [CNT_W-1:0]              name_cnt_ff, name_cnt_in;
   logic                          star_ff, star_in;
   logic                          err_seen_ff, err_seen_in;

   // Result buffer: output register plus a skid slot.
   alp_pkg::rsp_type rsp_ff, rsp_in;
   alp_pkg::rsp_type skid_ff, skid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             skid_valid_ff, skid_valid_in;

   alp_pkg::rsp_type step_rsp;
   logic             accept;
   logic             drain;

   logic [alp_pkg::CHAR_W-1:0] c;
   logic is_lang, is_blank, is_digit, is_comma, is_nul;
   logic err, close, fin, closable;
   logic [7:0]  name_cnt_wide;
   logic [10:0] digit_product;

   assign c        = req_char_in;
   assign is_lang  = (c >= alp_pkg::CHAR_VIS_LO) && (c <= alp_pkg::CHAR_VIS_HI) &&
                     (c != alp_pkg::CHAR_SEMI);
   assign is_blank = (c == alp_pkg::CHAR_SPACE) || (c == alp_pkg::CHAR_TAB);
   assign is_digit = (c >= alp_pkg::CHAR_ZERO) && (c <= alp_pkg::CHAR_NINE);
   assign is_comma = (c == alp_pkg::CHAR_COMMA);
   assign is_nul   = (c == alp_pkg::CHAR_NUL);

   // The count is widened to a byte so that the fixed-width result fields can be cut
   // from it whatever the counter width is.
   assign name_cnt_wide = 8'(name_cnt_ff);

   // Digit value times its place weight: at most 900, so it fits the quality field.
   assign digit_product = 11'(c[3:0]) * 11'(alp_pkg::place_weight(digits_ff));

   // One step of the byte state machine. Everything it needs is the current byte and the
   // state registers, so a new byte can be taken in every cycle while req_ready is high.
   always_comb begin
      state_in    = state_ff;
      quality_in  = quality_ff;
      digits_in   = digits_ff;
      name_cnt_in = name_cnt_ff;
      star_in     = star_ff;
      err_seen_in = err_seen_ff;

      step_rsp           = '0;
      step_rsp.char_echo = c;

      err      = 1'b0;
      close    = 1'b0;
      fin      = 1'b0;
      closable = 1'b0;

      // A name byte counts only while the name is below its limit. A comma is a visible
      // byte but always separates entries, so it never belongs to a name.
      if (!err_seen_ff && is_lang && !is_comma &&
          (state_ff == ST_START || state_ff == ST_SEP || state_ff == ST_LANG) &&
          (name_cnt_ff < CNT_W'(NAME_MAX))) begin
         step_rsp.is_name_char  = 1'b1;
         step_rsp.name_position = name_cnt_wide[alp_pkg::POS_W-1:0];
         if (name_cnt_ff == '0) begin
            star_in = (c == alp_pkg::CHAR_STAR);
         end
         name_cnt_in = name_cnt_ff + CNT_W'(1);
      end

      if (err_seen_ff) begin
         // Throw bytes away until the terminator, which restarts the header.
         step_rsp.status = alp_pkg::STATUS_DISCARD;
      end else begin
         unique case (state_ff)
            ST_START: begin
               if (is_comma) begin
                  close    = 1'b1;
                  state_in = ST_SEP;
               end else if (is_lang) begin
                  state_in = ST_LANG;
               end else begin
                  err = 1'b1;
               end
            end
            ST_SEP: begin
               if (is_blank || is_comma) begin
                  state_in = ST_SEP;
               end else if (is_nul) begin
                  fin = 1'b1;
               end else if (is_lang) begin
                  state_in = ST_LANG;
               end else begin
                  err = 1'b1;
               end
            end
            ST_LANG: begin
               if (is_comma || is_nul) begin
                  closable = 1'b1;
               end else if (c == alp_pkg::CHAR_SEMI) begin
                  state_in = ST_SEMI;
               end else if (is_blank) begin
                  state_in = ST_OWS1;
               end else if (!is_lang) begin
                  err = 1'b1;
               end
            end
            ST_OWS1: begin
               if (c == alp_pkg::CHAR_SEMI) begin
                  state_in = ST_SEMI;
               end else if (!is_blank) begin
                  err = 1'b1;
               end
            end
            ST_SEMI, ST_OWS2: begin
               if (is_blank) begin
                  state_in = ST_OWS2;
               end else if (c == alp_pkg::CHAR_Q) begin
                  state_in = ST_Q;
               end else begin
                  err = 1'b1;
               end
            end
            ST_Q: begin
               if (c == alp_pkg::CHAR_EQUAL) begin
                  state_in = ST_QEQ;
               end else begin
                  err = 1'b1;
               end
            end
            ST_QEQ: begin
               if (c == alp_pkg::CHAR_ONE) begin
                  quality_in = alp_pkg::QUALITY_FULL;
                  state_in   = ST_ONE_INT;
               end else if (c == alp_pkg::CHAR_ZERO) begin
                  quality_in = '0;
                  state_in   = ST_ZERO_INT;
               end else begin
                  err = 1'b1;
               end
            end
            ST_ONE_INT: begin
               if (c == alp_pkg::CHAR_POINT) begin
                  state_in = ST_ONE_POINT;
               end else begin
                  closable = 1'b1;
               end
            end
            ST_ONE_POINT: begin
               if (c == alp_pkg::CHAR_ZERO) begin
                  digits_in = alp_pkg::DIGIT_W'(1);
                  state_in  = ST_ONE_DEC;
               end else begin
                  err = 1'b1;
               end
            end
            ST_ONE_DEC: begin
               if (c == alp_pkg::CHAR_ZERO && digits_ff < alp_pkg::DIGITS_MAX) begin
                  digits_in = digits_ff + alp_pkg::DIGIT_W'(1);
               end else begin
                  closable = 1'b1;
               end
            end
            ST_ZERO_INT: begin
               if (c == alp_pkg::CHAR_POINT) begin
                  state_in = ST_ZERO_POINT;
               end else begin
                  closable = 1'b1;
               end
            end
            ST_ZERO_POINT: begin
               // digits_ff is zero here, so the product carries the hundreds weight.
               if (is_digit) begin
                  quality_in = alp_pkg::QUAL_W'(digit_product);
                  digits_in  = alp_pkg::DIGIT_W'(1);
                  state_in   = ST_ZERO_DEC;
               end else begin
                  err = 1'b1;
               end
            end
            ST_ZERO_DEC: begin
               if (is_digit && digits_ff < alp_pkg::DIGITS_MAX) begin
                  quality_in = quality_ff + alp_pkg::QUAL_W'(digit_product);
                  digits_in  = digits_ff + alp_pkg::DIGIT_W'(1);
               end else begin
                  closable = 1'b1;
               end
            end
            default: begin
               err = 1'b1;
            end
         endcase

         // After a name or q-value only a comma or the terminator may follow.
         if (closable) begin
            if (is_comma) begin
               close    = 1'b1;
               state_in = ST_SEP;
            end else if (is_nul) begin
               close = 1'b1;
               fin   = 1'b1;
            end else begin
               err = 1'b1;
            end
         end

         if (close) begin
            step_rsp.entry_done  = 1'b1;
            step_rsp.quality     = quality_ff;
            step_rsp.name_length = name_cnt_wide[alp_pkg::LEN_W-1:0];
            step_rsp.is_wildcard = (name_cnt_ff == CNT_W'(1)) && star_ff;
            quality_in  = alp_pkg::QUALITY_FULL;
            digits_in   = '0;
            name_cnt_in = '0;
            star_in     = 1'b0;
         end

         if (err) begin
            step_rsp.status = alp_pkg::STATUS_ERROR;
            err_seen_in     = 1'b1;
         end else if (fin) begin
            step_rsp.status = alp_pkg::STATUS_DONE;
         end
      end

      // The terminator always ends the header, also after an error or a clean separator: the
      // parser goes back to the start of a new header.
      if (is_nul && (err_seen_ff || err || fin)) begin
         state_in    = ST_START;
         quality_in  = alp_pkg::QUALITY_FULL;
         digits_in   = '0;
         name_cnt_in = '0;
         star_in     = 1'b0;
         err_seen_in = 1'b0;
      end
   end

   // Result buffer control. A new word goes to the output register when it is free or
   // being emptied, otherwise to the skid slot; the skid slot refills the output first.
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign drain     = rsp_valid_ff && rsp_ready;

   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!rsp_valid_ff || drain) begin
         rsp_valid_in  = skid_valid_ff || accept;
         rsp_in        = skid_valid_ff ? skid_ff : step_rsp;
         skid_valid_in = 1'b0;
      end else if (accept) begin
         skid_in       = step_rsp;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_START;
         quality_ff    <= alp_pkg::QUALITY_FULL;
         digits_ff     <= '0;
         name_cnt_ff   <= '0;
         star_ff       <= 1'b0;
         err_seen_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff    <= state_in;
            quality_ff  <= quality_in;
            digits_ff   <= digits_in;
            name_cnt_ff <= name_cnt_in;
            star_ff     <= star_in;
            err_seen_ff <= err_seen_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_char_echo     = rsp_ff.char_echo;
   assign rsp_is_name_char  = rsp_ff.is_name_char;
   assign rsp_name_position = rsp_ff.name_position;
   assign rsp_entry_done    = rsp_ff.entry_done;
   assign rsp_quality       = rsp_ff.quality;
   assign rsp_name_length   = rsp_ff.name_length;
   assign rsp_is_wildcard   = rsp_ff.is_wildcard;
   assign rsp_status        = rsp_ff.status;

`ifndef SYNTH
   // The skid slot is only ever filled behind a full output register.
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid slot holds a word while the output register is empty");

   // A terminator taken while discarding brings the parser back to a clean header start.
   a_discard_recovers: assert property (@(posedge clock) disable iff (reset)
      (accept && err_seen_ff && is_nul) |=>
         (!err_seen_ff && state_ff == ST_START && name_cnt_ff == '0))
      else $error("parser did not restart after the terminator");

   // Name bytes are only flagged while the header is being parsed normally.
   a_name_only_parsing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.is_name_char) |->
         (rsp_ff.status == alp_pkg::STATUS_PARSING && !rsp_ff.entry_done))
      else $error("name byte flagged on an error, discard or closing word");
`endif

endmodule

`default_nettype wire
